FILE: rtl/occ_pkg.sv
// Shared types, constants and a helper function of the oven cook controller.
package occ_pkg;

   localparam int TICKS_PER_SECOND = 5;
   localparam int SUB_W            = (TICKS_PER_SECOND > 1) ? $clog2(TICKS_PER_SECOND) : 1;
   localparam int SEC_PER_MIN      = 60;
   localparam int CD_MAX           = 2047;
   localparam int SAT_SECONDS      = CD_MAX / TICKS_PER_SECOND;
   localparam int SAT_SUB          = CD_MAX % TICKS_PER_SECOND;
   localparam int TEMP_CEIL        = 1023;

   localparam logic [7:0] LED_MASK_INIT = 8'hFE;
   localparam logic [7:0] LED_ALL       = 8'hFF;

   localparam logic [8:0] SET_TIME_RST    = 9'd1;
   localparam logic [9:0] SET_TEMP_RST    = 10'd350;
   localparam logic [7:0] HOLD_THRESH_RST = 8'd5;
   localparam logic [9:0] TEMP_OFFSET_RST = 10'd300;
   localparam logic [9:0] GRILL_TEMP_RST  = 10'd500;

   localparam logic [1:0] HEAT_BOTH   = 2'b11;
   localparam logic [1:0] HEAT_BOTTOM = 2'b10;
   localparam logic [1:0] HEAT_TOP    = 2'b01;

   localparam logic [1:0] CSR_HOLD_THRESH = 2'd0;
   localparam logic [1:0] CSR_TEMP_OFFSET = 2'd1;
   localparam logic [1:0] CSR_GRILL_TEMP  = 2'd2;

   typedef enum logic [2:0] {
      REQ_TICK       = 3'd0,
      REQ_SEL_DOWN   = 3'd1,
      REQ_SEL_UP     = 3'd2,
      REQ_START_DOWN = 3'd3,
      REQ_START_UP   = 3'd4,
      REQ_KNOB       = 3'd5
   } req_code_type;

   typedef enum logic [2:0] {
      ST_SETUP   = 3'd0,
      ST_SELPEND = 3'd1,
      ST_COOK    = 3'd2,
      ST_RSTPEND = 3'd3,
      ST_DONE    = 3'd4
   } ctrl_state_type;

   typedef enum logic [1:0] {
      MODE_BAKE  = 2'd0,
      MODE_TOAST = 2'd1,
      MODE_BROIL = 2'd2
   } cook_mode_type;

   typedef struct packed {
      logic [7:0] hold_thresh;
      logic [9:0] temp_offset;
      logic [9:0] grill_temp;
   } cfg_type;

   typedef struct packed {
      logic [2:0] minutes;
      logic [5:0] seconds;
   } clock_time_type;

   typedef struct packed {
      ctrl_state_type   state;
      cook_mode_type    mode;
      logic             sel_temp;
      logic [8:0]       set_time;
      logic [9:0]       set_temp;
      logic [15:0]      free_ticks;
      logic [15:0]      press_start;
      logic [10:0]      countdown;
      logic [7:0]       led_step;
      logic [10:0]      led_mark;
      logic [7:0]       led;
      logic [7:0]       led_mask;
      logic [1:0]       heater;
      logic             inverted;
      clock_time_type   cd_time;   // countdown split into minutes and seconds
      logic [SUB_W-1:0] cd_sub;    // ticks within the current second
   } ctl_state_type;

   // Result beat, first field in the highest bits.
   typedef struct packed {
      logic        done_inverted;
      logic        bottom_heater;
      logic        top_heater;
      logic [7:0]  led_bar;
      logic [5:0]  shown_seconds;
      logic [2:0]  shown_minutes;
      logic [10:0] remaining_ticks;
      logic [9:0]  temperature;
      logic [8:0]  cook_seconds_set;
      logic        edit_temp;
      logic [1:0]  cook_mode;
      logic [2:0]  ctrl_state;
   } rsp_fields_type;

   // Split a seconds count of at most 299 into minutes and seconds.
   function automatic clock_time_type split_seconds(input logic [8:0] secs);
      clock_time_type t;
      t.minutes = 3'd0;
      t.seconds = 6'(secs);
      for (int k = 1; k <= 4; k++) begin
         if (secs >= 9'(k * SEC_PER_MIN)) begin
            t.minutes = 3'(k);
            t.seconds = 6'(secs - 9'(k * SEC_PER_MIN));
         end
      end
      return t;
   endfunction

endpackage

FILE: rtl/oven_cook_controller.sv
// Top level of the oven cook controller: event input stage, controller, result register.
//
//  channel | dir | handshake             | payload
//  --------+-----+-----------------------+------------------------------------------
//  req     | in  | req_tvalid/req_tready | tuser: req_type; tdata: knob_value
//  rsp     | out | rsp_tvalid/rsp_tready | tdata: display, heater and progress fields
//  csr     | in  | csr_we                | csr_index selects register, csr_wdata value
//
// Each event beat is held in the input register and is applied to the controller
// state in the cycle it moves to the result register. One beat per cycle is
// sustained while rsp_tready stays high. The single result register is the only
// stall point; while it holds an untaken beat the input register still takes one more event.
// Reset (synchronous, active high) restores the power-up settings and registers.
module oven_cook_controller (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [2:0]  req_tuser,  // [2:0] req_type
   input  logic [15:0] req_tdata,  // [9:0] knob_value, [15:10] zero
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   // [2:0] ctrl_state, [4:3] cook_mode, [5] edit_temp, [14:6] cook_seconds_set,
   // [24:15] temperature, [35:25] remaining_ticks, [38:36] shown_minutes,
   // [44:39] shown_seconds, [52:45] led_bar, [53] top_heater, [54] bottom_heater,
   // [55] done_inverted
   output logic [55:0] rsp_tdata,
   input  logic        csr_we,
   input  logic [1:0]  csr_index,
   input  logic [9:0]  csr_wdata
);

   // Configuration registers; the user must write them only while no event is in flight (not enforced here)
   occ_pkg::cfg_type cfg_ff, cfg_in;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_we) begin
         case (csr_index)
            occ_pkg::CSR_HOLD_THRESH: cfg_in.hold_thresh = csr_wdata[7:0];
            occ_pkg::CSR_TEMP_OFFSET: cfg_in.temp_offset = csr_wdata;
            occ_pkg::CSR_GRILL_TEMP:  cfg_in.grill_temp  = csr_wdata;
            default:                  cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.hold_thresh <= occ_pkg::HOLD_THRESH_RST;
         cfg_ff.temp_offset <= occ_pkg::TEMP_OFFSET_RST;
         cfg_ff.grill_temp  <= occ_pkg::GRILL_TEMP_RST;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   // Input register and result register handshake
   logic                    in_vld_ff, in_vld_in;
   logic [2:0]              in_req_ff;
   logic [9:0]              in_knob_ff;
   logic                    out_vld_ff, out_vld_in;
   occ_pkg::rsp_fields_type out_data_ff;
   logic                    advance;
   logic                    take;

   occ_pkg::ctl_state_type  next_st;
   occ_pkg::rsp_fields_type fields;

   // Move the held event into the result register when the result slot is free or being taken
   assign advance    = in_vld_ff && (!out_vld_ff || rsp_tready);
   assign req_tready = !in_vld_ff || advance;
   assign take       = req_tvalid && req_tready;

   always_comb begin
      if (take) begin
         in_vld_in = 1'b1;
      end else if (advance) begin
         in_vld_in = 1'b0;
      end else begin
         in_vld_in = in_vld_ff;
      end
      if (advance) begin
         out_vld_in = 1'b1;
      end else if (rsp_tready) begin
         out_vld_in = 1'b0;
      end else begin
         out_vld_in = out_vld_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_vld_ff  <= 1'b0;
         out_vld_ff <= 1'b0;
      end else begin
         in_vld_ff  <= in_vld_in;
         out_vld_ff <= out_vld_in;
      end
   end

   // Payload registers: capture on accept, hold otherwise
   always_ff @(posedge clock) begin
      if (take) begin
         in_req_ff  <= req_tuser;
         in_knob_ff <= req_tdata[9:0];
      end
      if (advance) begin
         out_data_ff <= fields;
      end
   end

   occ_ctrl u_ctrl (
      .clock   (clock),
      .reset   (reset),
      .step    (advance),
      .req     (in_req_ff),
      .knob    (in_knob_ff),
      .cfg     (cfg_ff),
      .next_st (next_st)
   );

   occ_disp u_disp (
      .st         (next_st),
      .grill_temp (cfg_ff.grill_temp),
      .fields     (fields)
   );

   assign rsp_tvalid = out_vld_ff;
   assign rsp_tdata  = out_data_ff;

endmodule

FILE: rtl/occ_ctrl.sv
// Controller state registers and the per-event next-state logic.
module occ_ctrl (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   step,
   input  logic [2:0]             req,
   input  logic [9:0]             knob,
   input  occ_pkg::cfg_type       cfg,
   output occ_pkg::ctl_state_type next_st
);

   occ_pkg::ctl_state_type st_ff, st_in;

   localparam occ_pkg::clock_time_type SAT_TIME =
      occ_pkg::split_seconds(9'(occ_pkg::SAT_SECONDS));

   localparam logic [occ_pkg::SUB_W-1:0] SUB_W_MAX =
      occ_pkg::SUB_W'(occ_pkg::TICKS_PER_SECOND - 1);

   localparam logic [occ_pkg::SUB_W-1:0] SUB_ONE = occ_pkg::SUB_W'(1);

   function automatic occ_pkg::ctl_state_type halt_heat(input occ_pkg::ctl_state_type s);
      occ_pkg::ctl_state_type r;
      r            = s;
      r.led        = 8'd0;
      r.free_ticks = 16'd0;
      r.heater     = 2'd0;
      r.led_mask   = occ_pkg::LED_MASK_INIT;
      return r;
   endfunction

   // One tick of the countdown: keep the minute/second/tick split and the LED bar in step
   function automatic occ_pkg::ctl_state_type count_down(input occ_pkg::ctl_state_type s);
      occ_pkg::ctl_state_type r;
      logic [10:0]            cd;
      r  = s;
      cd = s.countdown - 11'd1;
      if (s.countdown != 11'd0) begin
         r.countdown = cd;
         if (s.cd_sub != '0) begin
            r.cd_sub = s.cd_sub - SUB_ONE;
         end else begin
            r.cd_sub = SUB_W_MAX;
            if (s.cd_time.seconds != 6'd0) begin
               r.cd_time.seconds = s.cd_time.seconds - 6'd1;
            end else begin
               r.cd_time.seconds = 6'(occ_pkg::SEC_PER_MIN - 1);
               r.cd_time.minutes = s.cd_time.minutes - 3'd1;
            end
         end
         if (cd == s.led_mark) begin
            r.led_mark = s.led_mark - 11'(s.led_step);
            r.led      = s.led & s.led_mask;
            r.led_mask = {s.led_mask[6:0], 1'b0};
         end
      end
      return r;
   endfunction

   logic [15:0] held;
   logic        is_long;
   logic        req_ok;
   logic [15:0] tick_prod;
   logic        cd_sat;
   logic [10:0] temp_sum;

   always_comb begin
      st_in = st_ff;
      if (req == occ_pkg::REQ_TICK) begin
         st_in.free_ticks = st_ff.free_ticks + 16'd1;
      end
      held      = st_in.free_ticks - st_ff.press_start;
      is_long   = (held >= 16'(cfg.hold_thresh));
      req_ok    = (req <= occ_pkg::REQ_KNOB);
      tick_prod = 16'(st_ff.set_time) * 16'(occ_pkg::TICKS_PER_SECOND);
      cd_sat    = (tick_prod > 16'(occ_pkg::CD_MAX));
      temp_sum  = 11'(knob[9:2]) + 11'(cfg.temp_offset);

      if (req_ok) begin
         case (st_ff.state)
            occ_pkg::ST_SETUP: begin
               if (req == occ_pkg::REQ_SEL_DOWN) begin
                  st_in.press_start = st_in.free_ticks;
                  st_in.state       = occ_pkg::ST_SELPEND;
               end else if (req == occ_pkg::REQ_START_DOWN) begin
                  if (cd_sat) begin
                     st_in.countdown = 11'(occ_pkg::CD_MAX);
                     st_in.cd_time   = SAT_TIME;
                     st_in.cd_sub    = occ_pkg::SUB_W'(occ_pkg::SAT_SUB);
                  end else begin
                     st_in.countdown = tick_prod[10:0];
                     st_in.cd_time   = occ_pkg::split_seconds(st_ff.set_time);
                     st_in.cd_sub    = '0;
                  end
                  st_in.led_step = st_in.countdown[10:3];
                  st_in.led_mark = st_in.countdown - 11'(st_in.countdown[10:3]);
                  st_in.led      = occ_pkg::LED_ALL;
                  case (st_ff.mode)
                     occ_pkg::MODE_BAKE:  st_in.heater = occ_pkg::HEAT_BOTH;
                     occ_pkg::MODE_TOAST: st_in.heater = occ_pkg::HEAT_BOTTOM;
                     default:             st_in.heater = occ_pkg::HEAT_TOP;
                  endcase
                  st_in.state = occ_pkg::ST_COOK;
               end else if (req == occ_pkg::REQ_KNOB) begin
                  if (!st_ff.sel_temp) begin
                     st_in.set_time = 9'(knob[9:2]) + 9'd1;
                  end else begin
                     st_in.set_temp = (temp_sum > 11'(occ_pkg::TEMP_CEIL)) ?
                                      10'(occ_pkg::TEMP_CEIL) : temp_sum[9:0];
                  end
               end
            end
            occ_pkg::ST_SELPEND: begin
               if (req == occ_pkg::REQ_SEL_UP) begin
                  if (!is_long) begin
                     case (st_ff.mode)
                        occ_pkg::MODE_BROIL: st_in.mode = occ_pkg::MODE_BAKE;
                        occ_pkg::MODE_BAKE: begin
                           st_in.mode     = occ_pkg::MODE_TOAST;
                           st_in.sel_temp = 1'b0;
                        end
                        default: begin
                           st_in.mode     = occ_pkg::MODE_BROIL;
                           st_in.sel_temp = 1'b0;
                        end
                     endcase
                  end else if (st_ff.mode == occ_pkg::MODE_BAKE) begin
                     st_in.sel_temp = ~st_ff.sel_temp;
                  end
                  st_in.state = occ_pkg::ST_SETUP;
               end
            end
            occ_pkg::ST_COOK: begin
               if (req == occ_pkg::REQ_START_DOWN) begin
                  st_in.press_start = st_in.free_ticks;
                  st_in.state       = occ_pkg::ST_RSTPEND;
               end
               if (st_ff.countdown == 11'd0) begin
                  st_in          = halt_heat(st_in);
                  st_in.state    = occ_pkg::ST_DONE;
                  st_in.inverted = 1'b1;
               end else if (req == occ_pkg::REQ_TICK) begin
                  st_in = count_down(st_in);
               end
            end
            occ_pkg::ST_RSTPEND: begin
               if (req == occ_pkg::REQ_START_UP) begin
                  if (is_long) begin
                     st_in       = halt_heat(st_in);
                     st_in.state = occ_pkg::ST_SETUP;
                  end else begin
                     st_in.state = occ_pkg::ST_COOK;
                  end
               end else if (req == occ_pkg::REQ_TICK) begin
                  st_in = count_down(st_in);
               end
            end
            default: begin
               if (req == occ_pkg::REQ_START_DOWN) begin
                  st_in.state    = occ_pkg::ST_SETUP;
                  st_in.inverted = 1'b0;
               end
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff.state       <= occ_pkg::ST_SETUP;
         st_ff.mode        <= occ_pkg::MODE_BAKE;
         st_ff.sel_temp    <= 1'b0;
         st_ff.set_time    <= occ_pkg::SET_TIME_RST;
         st_ff.set_temp    <= occ_pkg::SET_TEMP_RST;
         st_ff.free_ticks  <= 16'd0;
         st_ff.press_start <= 16'd0;
         st_ff.countdown   <= 11'd0;
         st_ff.led_step    <= 8'd0;
         st_ff.led_mark    <= 11'd0;
         st_ff.led         <= 8'd0;
         st_ff.led_mask    <= occ_pkg::LED_MASK_INIT;
         st_ff.heater      <= 2'd0;
         st_ff.inverted    <= 1'b0;
         st_ff.cd_time     <= '0;
         st_ff.cd_sub      <= '0;
      end else if (step) begin
         st_ff <= st_in;
      end
   end

   assign next_st = st_in;

endmodule

FILE: rtl/occ_disp.sv
// Result fields derived from the controller state after an event.
module occ_disp (
   input  occ_pkg::ctl_state_type  st,
   input  logic [9:0]              grill_temp,
   output occ_pkg::rsp_fields_type fields
);

   occ_pkg::clock_time_type shown;
   logic                    counting;

   always_comb begin
      counting = (st.state == occ_pkg::ST_COOK) || (st.state == occ_pkg::ST_RSTPEND);
      shown    = counting ? st.cd_time : occ_pkg::split_seconds(st.set_time);

      fields.ctrl_state       = st.state;
      fields.cook_mode        = st.mode;
      fields.edit_temp        = st.sel_temp;
      fields.cook_seconds_set = st.set_time;
      fields.temperature      = (st.mode == occ_pkg::MODE_BROIL) ? grill_temp : st.set_temp;
      fields.remaining_ticks  = st.countdown;
      fields.shown_minutes    = shown.minutes;
      fields.shown_seconds    = shown.seconds;
      fields.led_bar          = st.led;
      fields.top_heater       = st.heater[0];
      fields.bottom_heater    = st.heater[1];
      fields.done_inverted    = st.inverted;
   end

endmodule
